// ===== rtl/core/pwq_pkg.sv =====
// Shared types and constants for the priority-ordered wait queue.
// Used by pwq_cell and priority_ordered_wait_queue; no dependencies.
`default_nettype none

package pwq_pkg;

  // Kernel actions carried by one input item
  typedef enum logic [2:0] {
    ACT_WAIT       = 3'd0,
    ACT_WAKE_HEAD  = 3'd1,
    ACT_WAKE_NAMED = 3'd2,
    ACT_RELEASE    = 3'd3,
    ACT_FLUSH      = 3'd4
  } action_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD         = 2'd0,
    CELL_INSERT       = 2'd1,
    CELL_REMOVE_NAMED = 2'd2,
    CELL_REMOVE_HEAD  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     by_prio;
  } cell_ctrl_t;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_PRIORITY_MODE = 1'b0;  // register index, paddr[2]

endpackage

`default_nettype wire

// ===== rtl/core/priority_ordered_wait_queue.sv =====
// Top level of the priority-ordered wait queue: command sequencer,
// configuration register and a chain of pwq_cell slots.
// Depends on pwq_pkg and pwq_cell.
//
// Channel   Ports                                     Handshake
// -------   ----------------------------------------  ----------------------------
// command   start, busy, action_i .. wait_ticks_i     taken when start & !busy
// result    result_valid_o, woken_task_o .. last_o    one-cycle strobe, no stall
// config    psel, penable, pwrite, paddr, pwdata,     APB, written at access phase
//           prdata, pready                            pready tied high
//
// An item is taken at one edge, applied to the chain in the following cycle
// (one parallel compare per cell plus the hit chain along the row) and its
// result appears on the strobe in the cycle after that; no item is taken while busy.
// A flush of N waiters emits one item per cycle from the head.
// Reset empties the queue (slot valid bits clear) and selects priority mode.
// The receiver cannot stall; results are never held back.
`default_nettype none

module priority_ordered_wait_queue import pwq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TASK_BITS   = 5,
  parameter int unsigned PRIO_BITS   = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [2:0]                        action_i,
  input  wire logic [TASK_BITS-1:0]              task_id_i,
  input  wire logic [PRIO_BITS-1:0]              priority_req_i,
  input  wire logic [31:0]                       message_i,
  input  wire logic [7:0]                        wait_result_i,
  input  wire logic [31:0]                       wait_ticks_i,
  // result
  output logic                                   result_valid_o,
  output logic [TASK_BITS-1:0]                   woken_task_o,
  output logic                                   woken_valid_o,
  output logic [31:0]                            woken_message_o,
  output logic [7:0]                             woken_result_o,
  output logic                                   make_ready_o,
  output logic [31:0]                            start_timeout_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       waiters_before_o,
  output logic                                   queue_full_drop_o,
  output logic                                   not_found_o,
  output logic                                   last_o,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [CFG_ADDR_W-1:0]             paddr,
  input  wire logic [CFG_DATA_W-1:0]             pwdata,
  output logic [CFG_DATA_W-1:0]                  prdata,
  output logic                                   pready
);

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic mode_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PRIORITY_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  // Unmapped addresses read as zero
  assign prdata = (paddr[2] == REG_PRIORITY_MODE) ? {{(CFG_DATA_W-1){1'b0}}, mode_q}
                                                  : '0;

  // ---------------------------------------------------------------------
  // Command capture
  // ---------------------------------------------------------------------
  state_e               state_q, state_d;
  action_e              act_q;
  logic [TASK_BITS-1:0] key_task_q;
  logic [PRIO_BITS-1:0] key_prio_q;
  logic [31:0]          msg_q;
  logic [7:0]           res_q;
  logic [31:0]          ticks_q;
  logic [OCC_W-1:0]     before_q;
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic                 accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q      <= action_e'(action_i);
      key_task_q <= task_id_i;
      key_prio_q <= priority_req_i;
      msg_q      <= message_i;
      res_q      <= wait_result_i;
      ticks_q    <= wait_ticks_i;
      before_q   <= occ_q;  // occupancy seen by this item
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain; ext_* pads an empty slot at both ends
  // ---------------------------------------------------------------------
  cell_ctrl_t           cell_ctrl;
  logic [QUEUE_DEPTH:0] hit_chain;
  logic                 ext_valid [QUEUE_DEPTH+2];
  logic [TASK_BITS-1:0] ext_task  [QUEUE_DEPTH+2];
  logic [PRIO_BITS-1:0] ext_prio  [QUEUE_DEPTH+2];
  logic [QUEUE_DEPTH-1:0] cell_valid;

  assign ext_valid[0]             = 1'b0;
  assign ext_task[0]              = '0;
  assign ext_prio[0]              = '0;
  assign ext_valid[QUEUE_DEPTH+1] = 1'b0;
  assign ext_task[QUEUE_DEPTH+1]  = '0;
  assign ext_prio[QUEUE_DEPTH+1]  = '0;

  // Head removal and flush shift every slot
  assign hit_chain[0] = (cell_ctrl.op == CELL_REMOVE_HEAD);

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    pwq_cell #(
      .TASK_BITS (TASK_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .key_task_i    (key_task_q),
      .key_prio_i    (key_prio_q),
      .hit_i         (hit_chain[gi]),
      .hit_o         (hit_chain[gi+1]),
      .left_valid_i  (ext_valid[gi]),
      .left_task_i   (ext_task[gi]),
      .left_prio_i   (ext_prio[gi]),
      .right_valid_i (ext_valid[gi+2]),
      .right_task_i  (ext_task[gi+2]),
      .right_prio_i  (ext_prio[gi+2]),
      .valid_o       (ext_valid[gi+1]),
      .task_o        (ext_task[gi+1]),
      .prio_o        (ext_prio[gi+1])
    );
    assign cell_valid[gi] = ext_valid[gi+1];
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  logic occ_empty, occ_full, occ_one;

  assign occ_empty = (occ_q == '0);
  assign occ_full  = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign occ_one   = (occ_q == OCC_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      // Stay while a flush still has entries after this one
      ST_EXEC: if (!((act_q == ACT_FLUSH) && !occ_empty && !occ_one)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (cell operation and result of this cycle)
  // ---------------------------------------------------------------------
  logic                 rv_d, wv_d, rdy_d, drop_d, nf_d, last_d;
  logic [TASK_BITS-1:0] wtask_d;
  logic [31:0]          wmsg_d, tmo_d;
  logic [7:0]           wres_d;

  always_comb begin
    busy              = (state_q != ST_IDLE);
    cell_ctrl.op      = CELL_HOLD;
    cell_ctrl.by_prio = mode_q;
    occ_d             = occ_q;
    rv_d              = 1'b0;
    wtask_d           = '0;
    wv_d              = 1'b0;
    wmsg_d            = '0;
    wres_d            = '0;
    rdy_d             = 1'b0;
    tmo_d             = '0;
    drop_d            = 1'b0;
    nf_d              = 1'b0;
    last_d            = 1'b1;
    if (state_q == ST_EXEC) begin
      rv_d = 1'b1;
      unique case (act_q)
        ACT_WAIT: begin
          if (occ_full) begin
            drop_d = 1'b1;
          end else begin
            cell_ctrl.op = CELL_INSERT;
            occ_d        = occ_q + OCC_W'(1);
            tmo_d        = ticks_q;
          end
        end
        ACT_WAKE_HEAD: begin
          if (occ_empty) begin
            nf_d = 1'b1;
          end else begin
            cell_ctrl.op = CELL_REMOVE_HEAD;
            occ_d        = occ_q - OCC_W'(1);
            wtask_d      = ext_task[1];
            wv_d         = 1'b1;
            wmsg_d       = msg_q;
            wres_d       = res_q;
            rdy_d        = 1'b1;
          end
        end
        ACT_WAKE_NAMED, ACT_RELEASE: begin
          // Chain end tells whether any slot matched; a miss leaves all slots
          cell_ctrl.op = CELL_REMOVE_NAMED;
          if (hit_chain[QUEUE_DEPTH]) begin
            occ_d   = occ_q - OCC_W'(1);
            wtask_d = key_task_q;
            wv_d    = 1'b1;
            wmsg_d  = msg_q;
            wres_d  = res_q;
            rdy_d   = (act_q == ACT_WAKE_NAMED);
          end else begin
            nf_d = 1'b1;
          end
        end
        ACT_FLUSH: begin
          if (!occ_empty) begin
            cell_ctrl.op = CELL_REMOVE_HEAD;
            occ_d        = occ_q - OCC_W'(1);
            wtask_d      = ext_task[1];
            wv_d         = 1'b1;
            wmsg_d       = msg_q;
            wres_d       = res_q;
            rdy_d        = 1'b1;
            last_d       = occ_one;
          end
        end
        default: ;  // unused codes: empty result
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      occ_q          <= occ_d;
      result_valid_o <= rv_d;
    end
  end

  // Result payload, held in registers so the strobe comes straight off a flop
  always_ff @(posedge clk_i) begin
    if (rv_d) begin
      woken_task_o      <= wtask_d;
      woken_valid_o     <= wv_d;
      woken_message_o   <= wmsg_d;
      woken_result_o    <= wres_d;
      make_ready_o      <= rdy_d;
      start_timeout_o   <= tmo_d;
      waiters_before_o  <= before_q;
      queue_full_drop_o <= drop_d;
      not_found_o       <= nf_d;
      last_o            <= last_d;
    end
  end

`ifndef SYNTHESIS
  // Occupied slots form the count held in the occupancy register
  a_occ_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == occ_q)
    else $error("slot valid bits disagree with occupancy");

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // A result that is not the last of its item is followed by another
  a_flush_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("flush stopped before its last item");

  // Every accepted item produces its first result from the execute state via the result register
  a_item_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 result_valid_o)
    else $error("result missing after accepted item");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pwq_cell.sv =====
// One slot of the wait-queue chain: holds a task and its priority and
// shifts toward the tail on insert or toward the head on removal.
// Depends on pwq_pkg.
`default_nettype none

module pwq_cell import pwq_pkg::*; #(
  parameter int unsigned TASK_BITS = 5,
  parameter int unsigned PRIO_BITS = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic [TASK_BITS-1:0] key_task_i,
  input  wire logic [PRIO_BITS-1:0] key_prio_i,
  input  wire logic                 hit_i,
  output logic                      hit_o,
  input  wire logic                 left_valid_i,
  input  wire logic [TASK_BITS-1:0] left_task_i,
  input  wire logic [PRIO_BITS-1:0] left_prio_i,
  input  wire logic                 right_valid_i,
  input  wire logic [TASK_BITS-1:0] right_task_i,
  input  wire logic [PRIO_BITS-1:0] right_prio_i,
  output logic                      valid_o,
  output logic [TASK_BITS-1:0]      task_o,
  output logic [PRIO_BITS-1:0]      prio_o
);

  logic                 valid_q, valid_d;
  logic [TASK_BITS-1:0] task_q, task_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic                 match;

  // Insert: first empty slot, or in priority mode first strictly larger priority number.
  // Named removal: first slot holding the key task.
  always_comb begin
    case (ctrl_i.op)
      CELL_INSERT:       match = !valid_q || (ctrl_i.by_prio && (prio_q > key_prio_i));
      CELL_REMOVE_NAMED: match = valid_q && (task_q == key_task_i);
      default:           match = 1'b0;
    endcase
  end

  assign hit_o = hit_i | match;

  always_comb begin
    valid_d = valid_q;
    task_d  = task_q;
    prio_d  = prio_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (hit_i) begin
          valid_d = left_valid_i;
          task_d  = left_task_i;
          prio_d  = left_prio_i;
        end else if (match) begin
          valid_d = 1'b1;
          task_d  = key_task_i;
          prio_d  = key_prio_i;
        end
      end
      CELL_REMOVE_NAMED, CELL_REMOVE_HEAD: begin
        if (hit_o) begin
          valid_d = right_valid_i;
          task_d  = right_task_i;
          prio_d  = right_prio_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign task_o  = task_q;
  assign prio_o  = prio_q;

endmodule

`default_nettype wire
